// ----- rtl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Holds the command and character codes, the stream widths and the microcode ROM.
// No dependencies.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CMD_W       = 2;
    localparam int IN_TDATA_W  = 24;  // char_code(8), cell_col(7), cell_row(5), pad
    localparam int OUT_TDATA_W = 40;  // col(7), row(5), position(11), char(8), color(8), pad

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] RESET_COLOR = 8'h07;

    localparam int TAB_STOP = 4;
    localparam int TAB_BITS = $clog2(TAB_STOP);

    // datapath action of one microcode step
    typedef enum logic [3:0] {
        OP_NOP          = 4'd0,
        OP_ACCEPT       = 4'd1,
        OP_BLANK_BOOT   = 4'd2,
        OP_BLANK        = 4'd3,
        OP_GLYPH        = 4'd4,
        OP_NEWLINE      = 4'd5,
        OP_CR           = 4'd6,
        OP_SCROLL_SETUP = 4'd7,
        OP_CLEAR_SETUP  = 4'd8,
        OP_READ         = 4'd9,
        OP_RESULT       = 4'd10
    } op_t;

    // jump condition of one microcode step
    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_DISPATCH   = 3'd1,
        C_NO_SCROLL  = 3'd2,
        C_SWEEP_MORE = 3'd3,
        C_TAB_MORE   = 3'd4,
        C_OUT_BUSY   = 3'd5
    } cond_t;

    // microcode addresses
    typedef enum logic [3:0] {
        S_BOOT      = 4'd0,
        S_IDLE      = 4'd1,
        S_GLYPH     = 4'd2,
        S_NEWLINE   = 4'd3,
        S_SETTLE    = 4'd4,
        S_SCROLL    = 4'd5,
        S_NEXT      = 4'd6,
        S_CR        = 4'd7,
        S_CLEAR     = 4'd8,
        S_CLR_SWEEP = 4'd9,
        S_READ      = 4'd10,
        S_RESULT    = 4'd11
    } step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;   // taken when cond holds
        step_t next;   // otherwise
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        case (s)
            S_BOOT:      c = '{OP_BLANK_BOOT,   C_SWEEP_MORE, S_BOOT,      S_IDLE};
            S_IDLE:      c = '{OP_ACCEPT,       C_DISPATCH,   S_IDLE,      S_IDLE};
            S_GLYPH:     c = '{OP_GLYPH,        C_NEVER,      S_SETTLE,    S_SETTLE};
            S_NEWLINE:   c = '{OP_NEWLINE,      C_NEVER,      S_SETTLE,    S_SETTLE};
            S_SETTLE:    c = '{OP_SCROLL_SETUP, C_NO_SCROLL,  S_NEXT,      S_SCROLL};
            S_SCROLL:    c = '{OP_BLANK,        C_SWEEP_MORE, S_SCROLL,    S_NEXT};
            S_NEXT:      c = '{OP_NOP,          C_TAB_MORE,   S_GLYPH,     S_RESULT};
            S_CR:        c = '{OP_CR,           C_NEVER,      S_RESULT,    S_RESULT};
            S_CLEAR:     c = '{OP_CLEAR_SETUP,  C_NEVER,      S_CLR_SWEEP, S_CLR_SWEEP};
            S_CLR_SWEEP: c = '{OP_BLANK,        C_SWEEP_MORE, S_CLR_SWEEP, S_RESULT};
            S_READ:      c = '{OP_READ,         C_NEVER,      S_RESULT,    S_RESULT};
            S_RESULT:    c = '{OP_RESULT,       C_OUT_BUSY,   S_RESULT,    S_IDLE};
            default:     c = '{OP_NOP,          C_NEVER,      S_IDLE,      S_IDLE};
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/text_console_writer.sv -----
// Text console writer: character-cell store, cursor and microcoded control.
// Depends on tcw_pkg (codes, widths, microcode ROM).
//
// Usage:
//   Commands arrive on the s_ stream (tuser = command, tdata = char_code,
//   cell_col, cell_row); one result per command leaves on the m_ stream with
//   the cursor after the command and, for a read, the addressed cell.
//   cfg_wr_en/cfg_wr_data set the attribute used for blanked cells.
// Steps, from the transfer through the step that loads the result:
//   carriage return, read: their own step, then the result; unused command: the result
//   ordinary character, newline: cursor update, scroll check, tab check, result
//   tab: the character steps repeated for each space written
//   a scroll blanks COLUMNS cells, one blank cell per cycle on the store's
//   single write port; clear blanks all COLUMNS*ROWS cells the same way.
// The cursor rows live in a ring over the store, so a scroll only blanks one
// row and moves the top pointer.
// Reset: the sequencer first blanks every cell, one per cycle, with s_tready
// low; config writes are taken meanwhile.
// Stall: a finished result waits in the output register; the next command is
// taken and worked on, and its result waits until the register is free.
module text_console_writer
#(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [7:0]                       cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] char_code, [14:8] cell_col, [19:15] cell_row, [23:20] zero
    input  logic [tcw_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [1:0] command
    input  logic [tcw_pkg::CMD_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_position,
    // [30:23] read_char, [38:31] read_color, [39] zero
    output logic [tcw_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = $clog2(ROWS);
    localparam int RW    = $clog2(ROWS + 1);

    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROWS_R    = RW'(ROWS);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [PW-1:0] TOP_LAST  = PW'(ROWS - 1);
    localparam logic [PW:0]   ROWS_P    = (PW + 1)'(ROWS);
    localparam logic [7:0]    COL_LIMIT = 8'(COLUMNS);
    localparam logic [6:0]    ROW_LIMIT = 7'(ROWS);

    // logical row to store row through the ring's top pointer
    function automatic logic [PW-1:0] phys_row(input logic [PW-1:0] r,
                                               input logic [PW-1:0] t);
        logic [PW:0] s;
        s = {1'b0, r} + {1'b0, t};
        if (s >= ROWS_P)
        begin
            s = s - ROWS_P;
        end
        return PW'(s);
    endfunction

    // store
    logic [7:0] glyph_mem [CELLS];
    logic [7:0] attr_mem  [CELLS];
    logic [7:0] glyph_q;
    logic [7:0] attr_q;

    // control registers
    step_t          upc_reg,     upc_next;
    logic [AW-1:0]  sw_addr_reg, sw_addr_next;
    logic [LW-1:0]  sw_left_reg, sw_left_next;
    logic [PW-1:0]  top_reg,     top_next;
    logic [CW-1:0]  col_reg,     col_next;
    logic [RW-1:0]  row_reg,     row_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     default_color_reg;

    // payload registers
    logic [CMD_W-1:0]       cmd_reg;
    logic [7:0]             glyph_reg;
    logic [2:0]             tab_left_reg, tab_left_next;
    logic [6:0]             rc_reg;
    logic [4:0]             rr_reg;
    logic                   rd_ok_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    ctrl_t          ctrl;
    step_t          disp;
    logic           taken;
    logic [AW-1:0]  cur_addr;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  pos_full;
    logic           mem_we;
    logic           attr_we;
    logic [AW-1:0]  mem_addr;
    logic [7:0]     mem_glyph;
    logic [7:0]     mem_attr;
    logic           rd_en;
    logic           in_xfer;
    logic [7:0]     in_char;
    logic [6:0]     in_col;
    logic [4:0]     in_row;
    logic           out_free;

    assign in_char = s_tdata[7:0];
    assign in_col  = s_tdata[14:8];
    assign in_row  = s_tdata[19:15];

    assign ctrl     = ucode(upc_reg);
    assign s_tready = (ctrl.op == OP_ACCEPT);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign cur_addr = AW'(phys_row(PW'(row_reg), top_reg)) * COLS_A + AW'(col_reg);
    assign rd_addr  = AW'(phys_row(PW'(rr_reg), top_reg)) * COLS_A + AW'(CW'(rc_reg));
    assign pos_full = AW'(row_reg) * COLS_A + AW'(col_reg);

    // command decode straight from the input stream
    always_comb
    begin
        disp = S_IDLE;
        if (s_tvalid)
        begin
            case (s_tuser)
                CMD_PUT:
                begin
                    case (in_char)
                        CH_NL:   disp = S_NEWLINE;
                        CH_CR:   disp = S_CR;
                        default: disp = S_GLYPH;
                    endcase
                end
                CMD_CLEAR: disp = S_CLEAR;
                CMD_READ:  disp = S_READ;
                default:   disp = S_RESULT;
            endcase
        end
    end

    always_comb
    begin
        case (ctrl.cond)
            C_NO_SCROLL:  taken = (row_reg != ROWS_R);
            C_SWEEP_MORE: taken = (sw_left_reg != LW'(1));
            C_TAB_MORE:   taken = (tab_left_reg != 3'd0);
            C_OUT_BUSY:   taken = !out_free;
            default:      taken = 1'b0;
        endcase
        if (ctrl.cond == C_DISPATCH)
        begin
            upc_next = disp;
        end
        else
        begin
            upc_next = taken ? ctrl.jump : ctrl.next;
        end
    end

    // datapath
    always_comb
    begin
        sw_addr_next   = sw_addr_reg;
        sw_left_next   = sw_left_reg;
        top_next       = top_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        tab_left_next  = tab_left_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;
        attr_we        = 1'b0;
        mem_addr       = sw_addr_reg;
        mem_glyph      = CH_NUL;
        mem_attr       = default_color_reg;
        rd_en          = 1'b0;

        case (ctrl.op)
            OP_ACCEPT:
            begin
                if (in_xfer)
                begin
                    if (in_char == CH_TAB)
                    begin
                        tab_left_next = 3'(TAB_STOP) - 3'(col_reg[TAB_BITS-1:0]);
                    end
                    else
                    begin
                        tab_left_next = 3'd1;
                    end
                end
            end
            OP_BLANK_BOOT, OP_BLANK:
            begin
                mem_we       = 1'b1;
                attr_we      = 1'b1;
                mem_attr     = (ctrl.op == OP_BLANK_BOOT) ? RESET_COLOR : default_color_reg;
                sw_addr_next = sw_addr_reg + AW'(1);
                sw_left_next = sw_left_reg - LW'(1);
            end
            OP_GLYPH:
            begin
                mem_we        = 1'b1;
                mem_addr      = cur_addr;
                mem_glyph     = glyph_reg;
                tab_left_next = tab_left_reg - 3'd1;
                if (col_reg == COL_LAST)
                begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            OP_NEWLINE:
            begin
                col_next      = '0;
                row_next      = row_reg + RW'(1);
                tab_left_next = 3'd0;
            end
            OP_CR:
            begin
                col_next = '0;
            end
            OP_SCROLL_SETUP:
            begin
                // the old top row becomes the blank bottom row
                if (row_reg == ROWS_R)
                begin
                    row_next     = ROW_LAST;
                    sw_addr_next = AW'(top_reg) * COLS_A;
                    sw_left_next = LW'(COLUMNS);
                    top_next     = (top_reg == TOP_LAST) ? '0 : top_reg + PW'(1);
                end
            end
            OP_CLEAR_SETUP:
            begin
                sw_addr_next = '0;
                sw_left_next = LW'(CELLS);
                top_next     = '0;
                col_next     = '0;
                row_next     = '0;
            end
            OP_READ:
            begin
                rd_en = 1'b1;
            end
            OP_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg           <= S_BOOT;
            sw_addr_reg       <= '0;
            sw_left_reg       <= LW'(CELLS);
            top_reg           <= '0;
            col_reg           <= '0;
            row_reg           <= '0;
            out_valid_reg     <= 1'b0;
            default_color_reg <= RESET_COLOR;
        end
        else
        begin
            upc_reg       <= upc_next;
            sw_addr_reg   <= sw_addr_next;
            sw_left_reg   <= sw_left_next;
            top_reg       <= top_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                default_color_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tab_left_reg <= tab_left_next;
        if (in_xfer)
        begin
            cmd_reg   <= s_tuser;
            glyph_reg <= (in_char == CH_TAB) ? CH_SPACE : in_char;
            rc_reg    <= in_col;
            rr_reg    <= in_row;
            rd_ok_reg <= (s_tuser == CMD_READ) && ({1'b0, in_col} < COL_LIMIT)
                         && ({2'b00, in_row} < ROW_LIMIT);
        end
        if (ctrl.op == OP_RESULT && out_free)
        begin
            out_data_reg <= {1'b0,
                             (rd_ok_reg && cmd_reg == CMD_READ) ? attr_q  : 8'h00,
                             (rd_ok_reg && cmd_reg == CMD_READ) ? glyph_q : 8'h00,
                             11'(pos_full),
                             5'(row_reg),
                             7'(col_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            glyph_mem[mem_addr] <= mem_glyph;
        end
        if (rd_en)
        begin
            glyph_q <= glyph_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (attr_we)
        begin
            attr_mem[mem_addr] <= mem_attr;
        end
        if (rd_en)
        begin
            attr_q <= attr_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
